>>> hdl/lpct_pkg.sv
// ---------------------------------------------------------------------------
// lpct_pkg
// Shared types, codes and constants of the lidar point crop and transform unit.
// ---------------------------------------------------------------------------
package lpct_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int COEF_WIDTH_DEF  = 48;

  localparam int ROT_W      = 32;   // rotation terms, Q2.30
  localparam int POS_W      = 48;   // translations and world output, Q31.16
  localparam int FRAC_SHIFT = 30;
  localparam int SLOT_W     = 4;
  localparam int NUM_SLOTS  = 12;
  localparam int ROT_SLOTS  = 9;
  localparam int CFG_W      = 32;
  localparam int USER_W     = 3;    // operation, nan flag

  localparam logic signed [63:0] RANGE_LIMIT = 64'sd65536000;  // 1000 m in Q15.16

  localparam logic signed [ROT_W-1:0] ROT_MAX = {1'b0, {(ROT_W-1){1'b1}}};
  localparam logic signed [ROT_W-1:0] ROT_MIN = {1'b1, {(ROT_W-1){1'b0}}};
  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

  // config reset values
  localparam logic                    INV_EN_RST    = 1'b0;
  localparam logic                    BOX_EN_RST    = 1'b1;
  localparam logic signed [CFG_W-1:0] BOX_X_HI_RST  = 32'sd131072;
  localparam logic signed [CFG_W-1:0] BOX_X_LO_RST  = -32'sd131072;
  localparam logic signed [CFG_W-1:0] BOX_Y_HI_RST  = 32'sd196608;
  localparam logic signed [CFG_W-1:0] BOX_Y_LO_RST  = -32'sd327680;
  localparam logic                    HT_EN_RST     = 1'b0;
  localparam logic signed [CFG_W-1:0] HT_LIMIT_RST  = 32'sd327680;

  typedef enum logic [1:0] {
    OP_POINT    = 2'd0,
    OP_LOAD_VEH = 2'd1,
    OP_LOAD_WLD = 2'd2,
    OP_NONE     = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    CFG_INV_EN   = 3'd0,
    CFG_BOX_EN   = 3'd1,
    CFG_BOX_X_HI = 3'd2,
    CFG_BOX_X_LO = 3'd3,
    CFG_BOX_Y_HI = 3'd4,
    CFG_BOX_Y_LO = 3'd5,
    CFG_HT_EN    = 3'd6,
    CFG_HT_LIMIT = 3'd7
  } cfg_e;

  // fields carried unchanged from input to output
  typedef struct packed {
    logic [63:0] time_ns;
    logic [7:0]  strength;
    logic [15:0] position;
  } pass_t;

  // coefficient write request
  typedef struct packed {
    logic              en;
    logic              world;
    logic [SLOT_W-1:0] slot;
  } coef_wr_t;

  // width of an affine accumulator for a given coordinate width
  function automatic int acc_width(input int cw);
    return (((cw + 2) > POS_W) ? (cw + 2) : POS_W) + 2;
  endfunction

endpackage

>>> hdl/lpct_coef_bank.sv
// ---------------------------------------------------------------------------
// lpct_coef_bank
// Vehicle and world 3x4 coefficient tables, saturated as they are written.
// ---------------------------------------------------------------------------
module lpct_coef_bank #(
  parameter int COEF_WIDTH = lpct_pkg::COEF_WIDTH_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  lpct_pkg::coef_wr_t                    wr_i,
  input  logic signed [COEF_WIDTH-1:0]          wr_data_i,
  output logic signed [lpct_pkg::ROT_W-1:0]     veh_rot_o   [9],
  output logic signed [lpct_pkg::POS_W-1:0]     veh_trans_o [3],
  output logic signed [lpct_pkg::ROT_W-1:0]     wld_rot_o   [9],
  output logic signed [lpct_pkg::POS_W-1:0]     wld_trans_o [3]
);
  import lpct_pkg::*;

  logic signed [ROT_W-1:0] rot_sat;
  logic signed [POS_W-1:0] trans_sat;
  logic [1:0]              tidx;
  logic                    is_rot;
  logic                    is_trans;

  logic signed [ROT_W-1:0] veh_rot_q   [9];
  logic signed [POS_W-1:0] veh_trans_q [3];
  logic signed [ROT_W-1:0] wld_rot_q   [9];
  logic signed [POS_W-1:0] wld_trans_q [3];

  // rotation clamp to Q2.30
  always_comb begin
    if ((&wr_data_i[COEF_WIDTH-1:ROT_W-1]) || !(|wr_data_i[COEF_WIDTH-1:ROT_W-1])) begin
      rot_sat = wr_data_i[ROT_W-1:0];
    end else if (wr_data_i[COEF_WIDTH-1]) begin
      rot_sat = ROT_MIN;
    end else begin
      rot_sat = ROT_MAX;
    end
  end

  // translation to 48 bits
  if (COEF_WIDTH > POS_W) begin : g_trans_clamp
    always_comb begin
      if ((&wr_data_i[COEF_WIDTH-1:POS_W-1]) || !(|wr_data_i[COEF_WIDTH-1:POS_W-1])) begin
        trans_sat = wr_data_i[POS_W-1:0];
      end else if (wr_data_i[COEF_WIDTH-1]) begin
        trans_sat = POS_MIN;
      end else begin
        trans_sat = POS_MAX;
      end
    end
  end else if (COEF_WIDTH == POS_W) begin : g_trans_same
    assign trans_sat = wr_data_i;
  end else begin : g_trans_ext
    assign trans_sat = {{(POS_W-COEF_WIDTH){wr_data_i[COEF_WIDTH-1]}}, wr_data_i};
  end

  assign is_rot   = wr_i.en && (wr_i.slot < SLOT_W'(ROT_SLOTS));
  assign is_trans = wr_i.en && !is_rot && (wr_i.slot < SLOT_W'(NUM_SLOTS));
  assign tidx     = 2'(wr_i.slot - SLOT_W'(ROT_SLOTS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) begin
        veh_rot_q[i] <= '0;
        wld_rot_q[i] <= '0;
      end
      for (int i = 0; i < 3; i++) begin
        veh_trans_q[i] <= '0;
        wld_trans_q[i] <= '0;
      end
    end else begin
      if (is_rot) begin
        if (wr_i.world) begin
          wld_rot_q[wr_i.slot] <= rot_sat;
        end else begin
          veh_rot_q[wr_i.slot] <= rot_sat;
        end
      end
      if (is_trans) begin
        if (wr_i.world) begin
          wld_trans_q[tidx] <= trans_sat;
        end else begin
          veh_trans_q[tidx] <= trans_sat;
        end
      end
    end
  end

  assign veh_rot_o   = veh_rot_q;
  assign veh_trans_o = veh_trans_q;
  assign wld_rot_o   = wld_rot_q;
  assign wld_trans_o = wld_trans_q;

endmodule

>>> hdl/lpct_affine.sv
// ---------------------------------------------------------------------------
// lpct_affine
// Two-stage 3x4 affine product: nine registered products, then row sums.
// ---------------------------------------------------------------------------
module lpct_affine #(
  parameter int COORD_WIDTH = lpct_pkg::COORD_WIDTH_DEF,
  parameter int ACC_W       = lpct_pkg::acc_width(lpct_pkg::COORD_WIDTH_DEF)
) (
  input  logic                              clk_i,
  input  logic                              prod_en_i,
  input  logic                              sum_en_i,
  input  logic signed [COORD_WIDTH-1:0]     pos_i   [3],
  input  logic signed [lpct_pkg::ROT_W-1:0] rot_i   [9],
  input  logic signed [lpct_pkg::POS_W-1:0] trans_i [3],
  output logic signed [ACC_W-1:0]           acc_o   [3]
);
  import lpct_pkg::*;

  localparam int PROD_W = COORD_WIDTH + ROT_W;
  localparam int TERM_W = PROD_W - FRAC_SHIFT;

  logic signed [TERM_W-1:0] term_q [9];
  logic signed [ACC_W-1:0]  acc_q  [3];

  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar c = 0; c < 3; c++) begin : g_col
      logic signed [PROD_W-1:0] prod;
      assign prod = pos_i[c] * rot_i[r*3+c];
      // floor shift by 30 keeps Q.16
      always_ff @(posedge clk_i) begin
        if (prod_en_i) begin
          term_q[r*3+c] <= prod[PROD_W-1:FRAC_SHIFT];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (sum_en_i) begin
        acc_q[r] <= ACC_W'(trans_i[r]) + ACC_W'(term_q[r*3]) +
                    ACC_W'(term_q[r*3+1]) + ACC_W'(term_q[r*3+2]);
      end
    end
  end

  assign acc_o = acc_q;

endmodule

>>> hdl/lidar_point_crop_and_transform_unit.sv
// ---------------------------------------------------------------------------
// lidar_point_crop_and_transform_unit
// Lidar point stream crop-box / height / range filter with affine transforms.
// ---------------------------------------------------------------------------
// One beat per clock in, one kept point per clock out. A point takes five
// register stages from acceptance to the output register: input capture,
// range/NaN decision and coefficient write, the eighteen Q2.30 multipliers
// (vehicle and world tables in parallel, the longest path), the row sums,
// then box test and world clamp into the output register. Coefficient load
// beats (tuser operation 1 or 2) write their table when they reach the
// multiplier stage, so every point behind a load sees the new word and every
// point ahead of it the old one; loads and dropped points leave a bubble and
// produce no output beat. Operation 3 and slots above eleven are ignored.
// Each stage accepts whenever it is empty or its successor moves, so the input keeps
// flowing into any empty stage while a finished point waits on m_axis_tready, and
// stalls in the same cycle once all five stages are full. The user must write
// configuration through cfg_we_i only while the pipe is empty; the block itself does not enforce it.
// ---------------------------------------------------------------------------
module lidar_point_crop_and_transform_unit #(
  parameter int COORD_WIDTH = lpct_pkg::COORD_WIDTH_DEF,
  parameter int COEF_WIDTH  = lpct_pkg::COEF_WIDTH_DEF,
  parameter int IN_W  = ((lpct_pkg::SLOT_W + COEF_WIDTH + 3*COORD_WIDTH + 88 + 7) / 8) * 8,
  parameter int OUT_W = ((3*COORD_WIDTH + 3*lpct_pkg::POS_W + 88 + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config write port
  input  logic                          cfg_we_i,
  input  logic [2:0]                    cfg_index_i,
  input  logic [lpct_pkg::CFG_W-1:0]    cfg_data_i,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // coef_slot, coef_word, pos_x, pos_y, pos_z, echo_strength,
  // capture_time_ns, point_position, zero fill
  input  logic [IN_W-1:0]               s_axis_tdata,
  // operation, nan_flag
  input  logic [lpct_pkg::USER_W-1:0]   s_axis_tuser,
  // output stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // local_x, local_y, local_z, world_x, world_y, world_z, out_strength,
  // out_time_ns, out_position, zero fill
  output logic [OUT_W-1:0]              m_axis_tdata
);
  import lpct_pkg::*;

  localparam int CW    = COORD_WIDTH;
  localparam int KW    = COEF_WIDTH;
  localparam int ACC_W = acc_width(COORD_WIDTH);

  // input field offsets
  localparam int I_SLOT = 0;
  localparam int I_COEF = I_SLOT + SLOT_W;
  localparam int I_X    = I_COEF + KW;
  localparam int I_STR  = I_X + 3*CW;
  localparam int I_TIME = I_STR + 8;
  localparam int I_IDX  = I_TIME + 64;

  // output field offsets
  localparam int O_LOC  = 0;
  localparam int O_WLD  = O_LOC + 3*CW;
  localparam int O_STR  = O_WLD + 3*POS_W;
  localparam int O_TIME = O_STR + 8;
  localparam int O_IDX  = O_TIME + 64;

  // config registers
  logic                    inv_en_q, box_en_q, ht_en_q;
  logic signed [CFG_W-1:0] box_x_hi_q, box_x_lo_q, box_y_hi_q, box_y_lo_q, ht_limit_q;

  // stage valids and per-stage ready
  logic v0_q, v1_q, v2_q, v3_q, v4_q;
  logic rdy0, rdy1, rdy2, rdy3, rdy4;

  // stage 0: captured beat
  op_e                   op0_q;
  logic [SLOT_W-1:0]     slot0_q;
  logic signed [KW-1:0]  coef0_q;
  logic signed [CW-1:0]  pos0_q [3];
  logic                  nan0_q;
  pass_t                 pass0_q;

  // stage 1
  logic                  load1_q, world1_q;
  logic [SLOT_W-1:0]     slot1_q;
  logic signed [KW-1:0]  coef1_q;
  logic signed [CW-1:0]  pos1_q [3];
  pass_t                 pass1_q;

  // stages 2..4
  logic signed [CW-1:0]    pos2_q [3];
  logic signed [CW-1:0]    pos3_q [3];
  logic signed [CW-1:0]    pos4_q [3];
  logic signed [POS_W-1:0] wld4_q [3];
  pass_t                   pass2_q, pass3_q, pass4_q;

  // decisions
  logic                    is_load0, slot_ok0, out_of_range0, keep0;
  logic                    ht_drop1, box_hit3;
  logic signed [63:0]      pos0_wide [3];
  logic signed [POS_W-1:0] wld_sat3 [3];

  // coefficients and transforms
  coef_wr_t                coef_wr;
  logic signed [ROT_W-1:0] veh_rot   [9];
  logic signed [POS_W-1:0] veh_trans [3];
  logic signed [ROT_W-1:0] wld_rot   [9];
  logic signed [POS_W-1:0] wld_trans [3];
  logic signed [ACC_W-1:0] veh_acc   [3];
  logic signed [ACC_W-1:0] wld_acc   [3];

  // ---- configuration ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_en_q   <= INV_EN_RST;
      box_en_q   <= BOX_EN_RST;
      box_x_hi_q <= BOX_X_HI_RST;
      box_x_lo_q <= BOX_X_LO_RST;
      box_y_hi_q <= BOX_Y_HI_RST;
      box_y_lo_q <= BOX_Y_LO_RST;
      ht_en_q    <= HT_EN_RST;
      ht_limit_q <= HT_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_e'(cfg_index_i))
        CFG_INV_EN:   inv_en_q   <= cfg_data_i[0];
        CFG_BOX_EN:   box_en_q   <= cfg_data_i[0];
        CFG_BOX_X_HI: box_x_hi_q <= cfg_data_i;
        CFG_BOX_X_LO: box_x_lo_q <= cfg_data_i;
        CFG_BOX_Y_HI: box_y_hi_q <= cfg_data_i;
        CFG_BOX_Y_LO: box_y_lo_q <= cfg_data_i;
        CFG_HT_EN:    ht_en_q    <= cfg_data_i[0];
        CFG_HT_LIMIT: ht_limit_q <= cfg_data_i;
      endcase
    end
  end

  // ---- flow control: a stage moves when empty or when its successor moves ----
  assign rdy4 = !v4_q || m_axis_tready;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign rdy0 = !v0_q || rdy1;
  assign s_axis_tready = rdy0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy0) v0_q <= s_axis_tvalid;
      if (rdy1) v1_q <= v0_q && keep0;
      if (rdy2) v2_q <= v1_q && !load1_q && !ht_drop1;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q && !box_hit3;
    end
  end

  // ---- stage 0: capture ----
  always_ff @(posedge clk_i) begin
    if (rdy0) begin
      op0_q   <= op_e'(s_axis_tuser[1:0]);
      nan0_q  <= s_axis_tuser[2];
      slot0_q <= s_axis_tdata[I_SLOT +: SLOT_W];
      coef0_q <= s_axis_tdata[I_COEF +: KW];
      for (int k = 0; k < 3; k++) begin
        pos0_q[k] <= s_axis_tdata[I_X + k*CW +: CW];
      end
      pass0_q.strength <= s_axis_tdata[I_STR +: 8];
      pass0_q.time_ns  <= s_axis_tdata[I_TIME +: 64];
      pass0_q.position <= s_axis_tdata[I_IDX +: 16];
    end
  end

  // range and NaN check
  always_comb begin
    out_of_range0 = 1'b0;
    for (int k = 0; k < 3; k++) begin
      pos0_wide[k]  = 64'(pos0_q[k]);
      out_of_range0 = out_of_range0 || (pos0_wide[k] > RANGE_LIMIT) ||
                      (pos0_wide[k] < -RANGE_LIMIT);
    end
  end

  assign is_load0 = (op0_q == OP_LOAD_VEH) || (op0_q == OP_LOAD_WLD);
  assign slot_ok0 = slot0_q < SLOT_W'(NUM_SLOTS);
  assign keep0    = (is_load0 && slot_ok0) ||
                    ((op0_q == OP_POINT) && !(inv_en_q && (nan0_q || out_of_range0)));

  // ---- stage 1 ----
  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      load1_q  <= is_load0;
      world1_q <= (op0_q == OP_LOAD_WLD);
      slot1_q  <= slot0_q;
      coef1_q  <= coef0_q;
      pos1_q   <= pos0_q;
      pass1_q  <= pass0_q;
    end
  end

  // load beats write their table as they leave this stage
  assign coef_wr.en    = v1_q && load1_q && rdy2;
  assign coef_wr.world = world1_q;
  assign coef_wr.slot  = slot1_q;

  assign ht_drop1 = ht_en_q && (64'(pos1_q[2]) > 64'(ht_limit_q));

  lpct_coef_bank #(
    .COEF_WIDTH (KW)
  ) u_coef_bank (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (coef_wr),
    .wr_data_i   (coef1_q),
    .veh_rot_o   (veh_rot),
    .veh_trans_o (veh_trans),
    .wld_rot_o   (wld_rot),
    .wld_trans_o (wld_trans)
  );

  // ---- stages 2 and 3: products and row sums ----
  lpct_affine #(
    .COORD_WIDTH (CW),
    .ACC_W       (ACC_W)
  ) u_veh_affine (
    .clk_i     (clk_i),
    .prod_en_i (rdy2),
    .sum_en_i  (rdy3),
    .pos_i     (pos1_q),
    .rot_i     (veh_rot),
    .trans_i   (veh_trans),
    .acc_o     (veh_acc)
  );

  lpct_affine #(
    .COORD_WIDTH (CW),
    .ACC_W       (ACC_W)
  ) u_wld_affine (
    .clk_i     (clk_i),
    .prod_en_i (rdy2),
    .sum_en_i  (rdy3),
    .pos_i     (pos1_q),
    .rot_i     (wld_rot),
    .trans_i   (wld_trans),
    .acc_o     (wld_acc)
  );

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      pos2_q  <= pos1_q;
      pass2_q <= pass1_q;
    end
    if (rdy3) begin
      pos3_q  <= pos2_q;
      pass3_q <= pass2_q;
    end
  end

  // ---- stage 3 -> output register: box test at full precision, world clamp ----
  assign box_hit3 = box_en_q &&
                    (veh_acc[0] < ACC_W'(box_x_hi_q)) && (veh_acc[0] > ACC_W'(box_x_lo_q)) &&
                    (veh_acc[1] < ACC_W'(box_y_hi_q)) && (veh_acc[1] > ACC_W'(box_y_lo_q));

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if ((&wld_acc[k][ACC_W-1:POS_W-1]) || !(|wld_acc[k][ACC_W-1:POS_W-1])) begin
        wld_sat3[k] = wld_acc[k][POS_W-1:0];
      end else if (wld_acc[k][ACC_W-1]) begin
        wld_sat3[k] = POS_MIN;
      end else begin
        wld_sat3[k] = POS_MAX;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      pos4_q  <= pos3_q;
      wld4_q  <= wld_sat3;
      pass4_q <= pass3_q;
    end
  end

  // ---- output beat ----
  assign m_axis_tvalid = v4_q;

  always_comb begin
    m_axis_tdata = '0;
    for (int k = 0; k < 3; k++) begin
      m_axis_tdata[O_LOC + k*CW +: CW]       = pos4_q[k];
      m_axis_tdata[O_WLD + k*POS_W +: POS_W] = wld4_q[k];
    end
    m_axis_tdata[O_STR +: 8]   = pass4_q.strength;
    m_axis_tdata[O_TIME +: 64] = pass4_q.time_ns;
    m_axis_tdata[O_IDX +: 16]  = pass4_q.position;
  end

endmodule

>>> tb/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the lidar point crop and transform unit.
// ---------------------------------------------------------------------------
// A clocked driver feeds point and coefficient-load beats from a queue and,
// on each accepted beat, runs a behavioural model of the range, box and
// height filters and both affine transforms. Kept points go into a queue of
// expected beats, which a clocked monitor checks field by field against the
// output stream. Phases step through several filter settings (extremes
// included), idle/stall mixes, and one long output hold that backs the
// pipe up into its input.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import lpct_pkg::*;

  localparam int IN_W  = ((SLOT_W + 48 + 3*32 + 88 + 7) / 8) * 8;
  localparam int OUT_W = ((3*32 + 3*POS_W + 88 + 7) / 8) * 8;

  localparam longint ROT_HI     = 64'sd2147483647;       // Q2.30 clamp
  localparam longint POS_HI     = 64'sd140737488355327;  // 48-bit clamp
  localparam int     PIPE_SLACK = 12;   // five stages, plus margin
  localparam int     LONG_HOLD  = 400;  // output hold in the pressure phase
  localparam int     MAX_PRINTS = 50;

  localparam logic [31:0] Q16_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q16_MIN = 32'h8000_0000;

  // one input beat, unpacked
  typedef struct {
    op_e                op;
    logic [SLOT_W-1:0]  slot;
    logic signed [47:0] word;
    logic signed [31:0] px, py, pz;
    logic               nan;
    logic [7:0]         strength;
    logic [63:0]        stamp;
    logic [15:0]        idx;
  } beat_t;

  // one kept point as it should leave the block, raw bus bits
  typedef struct {
    logic [31:0] lx, ly, lz;
    logic [47:0] wx, wy, wz;
    logic [7:0]  strength;
    logic [63:0] stamp;
    logic [15:0] idx;
  } kept_pt_t;

  // ---- DUT signals; every input known from time zero
  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             cfg_we_i      = 1'b0;
  logic [2:0]       cfg_index_i   = '0;
  logic [CFG_W-1:0] cfg_data_i    = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata  = '0;
  logic [USER_W-1:0] s_axis_tuser = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;

  lidar_point_crop_and_transform_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // ---- bench state
  beat_t    pending_beats[$];  // beats waiting for the driver
  kept_pt_t kept_q[$];         // points the block must still emit
  beat_t    offered;           // beat currently on the input bus

  // model copy of the registers and coefficient tables
  bit     inv_en, box_en, ht_en;
  longint box_xh, box_xl, box_yh, box_yl, ht_lim;
  longint veh_tab[NUM_SLOTS];
  longint wld_tab[NUM_SLOTS];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_req = 1'b0;   // toggled to ask the receiver for a long hold
  bit hold_ack = 1'b0;
  int hold_left = 0;

  int n_errors = 0, n_points = 0, n_dropped = 0, n_loads = 0;
  int n_ignored = 0, n_checked = 0;

  // ---- clock and reset
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #3_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  // ---- model
  function automatic longint clamp(input longint v, input longint hi);
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // one row of the 3x4 affine: translation plus three floored Q2.30 products
  function automatic longint affine_row(input bit world, input int row,
                                        input longint x, input longint y,
                                        input longint z);
    longint coord[3];
    longint acc, c;
    int     col;
    coord[0] = x;
    coord[1] = y;
    coord[2] = z;
    acc = clamp(world ? wld_tab[9 + row] : veh_tab[9 + row], POS_HI);
    for (col = 0; col < 3; col++) begin
      c = world ? wld_tab[row*3 + col] : veh_tab[row*3 + col];
      acc += (clamp(c, ROT_HI) * coord[col]) >>> FRAC_SHIFT;
    end
    return acc;
  endfunction

  // update tables / filter one accepted beat, queueing the kept point
  function automatic void crop_and_transform(input beat_t b);
    longint   px, py, pz, vx, vy;
    kept_pt_t k;
    case (b.op)
      OP_LOAD_VEH, OP_LOAD_WLD: begin
        n_loads++;
        if (b.slot < NUM_SLOTS) begin
          if (b.op == OP_LOAD_VEH) veh_tab[b.slot] = longint'(b.word);
          else wld_tab[b.slot] = longint'(b.word);
        end else begin
          n_ignored++;
        end
      end
      OP_POINT: begin
        n_points++;
        px = longint'(b.px);
        py = longint'(b.py);
        pz = longint'(b.pz);
        // range limit is inclusive at exactly 1000 m
        if (inv_en && (b.nan ||
            px > RANGE_LIMIT || px < -RANGE_LIMIT ||
            py > RANGE_LIMIT || py < -RANGE_LIMIT ||
            pz > RANGE_LIMIT || pz < -RANGE_LIMIT)) begin
          n_dropped++;
          return;
        end
        // box test on full-precision vehicle x/y, strict bounds
        vx = affine_row(1'b0, 0, px, py, pz);
        vy = affine_row(1'b0, 1, px, py, pz);
        if (box_en && vx < box_xh && vx > box_xl && vy < box_yh && vy > box_yl) begin
          n_dropped++;
          return;
        end
        if (ht_en && pz > ht_lim) begin
          n_dropped++;
          return;
        end
        k.lx       = b.px;
        k.ly       = b.py;
        k.lz       = b.pz;
        k.wx       = 48'(clamp(affine_row(1'b1, 0, px, py, pz), POS_HI));
        k.wy       = 48'(clamp(affine_row(1'b1, 1, px, py, pz), POS_HI));
        k.wz       = 48'(clamp(affine_row(1'b1, 2, px, py, pz), POS_HI));
        k.strength = b.strength;
        k.stamp    = b.stamp;
        k.idx      = b.idx;
        kept_q = {kept_q, k};
      end
      default: n_ignored++;  // operation three
    endcase
  endfunction

  // ---- input driver: holds a beat until taken, then maybe idles
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) crop_and_transform(offered);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offered = pending_beats.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {4'b0, offered.idx, offered.stamp, offered.strength,
                            offered.pz, offered.py, offered.px, offered.word,
                            offered.slot};
          s_axis_tuser  <= {offered.nan, offered.op};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---- output ready: random stalls, or a counted long hold on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_ack      <= 1'b0;
      hold_left     <= 0;
    end else if (hold_req != hold_ack) begin
      hold_ack      <= hold_req;
      hold_left     <= LONG_HOLD;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---- monitor
  task automatic check_field(input string what, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      n_errors++;
      if (n_errors <= MAX_PRINTS)
        $display("%0t: %s mismatch, expected %h, got %h", $time, what, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i) begin
    kept_pt_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (kept_q.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_PRINTS)
          $display("%0t: output beat with nothing expected, expected none, got %h",
                   $time, m_axis_tdata);
      end else begin
        e = kept_q.pop_front();
        n_checked++;
        check_field("local_x",  e.lx,       m_axis_tdata[31:0]);
        check_field("local_y",  e.ly,       m_axis_tdata[63:32]);
        check_field("local_z",  e.lz,       m_axis_tdata[95:64]);
        check_field("world_x",  e.wx,       m_axis_tdata[143:96]);
        check_field("world_y",  e.wy,       m_axis_tdata[191:144]);
        check_field("world_z",  e.wz,       m_axis_tdata[239:192]);
        check_field("strength", e.strength, m_axis_tdata[247:240]);
        check_field("time_ns",  e.stamp,    m_axis_tdata[311:248]);
        check_field("position", e.idx,      m_axis_tdata[327:312]);
      end
    end
  end

  // ---- stimulus helpers
  function automatic logic [47:0] rand48();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[47:0];
  endfunction

  // mostly metres around the car, some full range, some at the 1000 m edge
  function automatic logic signed [31:0] rand_coord();
    int k;
    k = $urandom_range(99);
    if (k < 65) return 32'(int'($urandom_range(1310720)) - 655360);
    if (k < 80) return $urandom;
    if (k < 92) return ($urandom_range(1) ? 32'sd1 : -32'sd1) *
                       (32'sd65536000 + int'($urandom_range(2)) - 1);
    case ($urandom_range(2))
      0:       return 32'sd0;
      1:       return Q16_MAX;
      default: return Q16_MIN;
    endcase
  endfunction

  // rotation word: mostly within Q2.30 range, sometimes needing a clamp
  function automatic logic signed [47:0] rand_rot();
    if ($urandom_range(9) == 0) return rand48();
    return 48'(longint'($urandom_range(32'h8000_0000)) - 64'sd1073741824);
  endfunction

  // translation word: mostly within 100 m, sometimes the full 48 bits
  function automatic logic signed [47:0] rand_trans();
    if ($urandom_range(6) == 0) return rand48();
    return 48'(int'($urandom_range(13107200)) - 6553600);
  endfunction

  function automatic void push_point(input logic signed [31:0] x,
                                     input logic signed [31:0] y,
                                     input logic signed [31:0] z,
                                     input logic nan_v);
    beat_t b;
    b.op       = OP_POINT;
    b.slot     = 4'($urandom);
    b.word     = rand48();   // don't-care on points, kept busy anyway
    b.px       = x;
    b.py       = y;
    b.pz       = z;
    b.nan      = nan_v;
    b.strength = 8'($urandom);
    b.stamp    = {$urandom, $urandom};
    b.idx      = 16'($urandom);
    pending_beats = {pending_beats, b};
  endfunction

  function automatic void push_load(input op_e op, input logic [SLOT_W-1:0] slot,
                                    input logic signed [47:0] word);
    beat_t b;
    b.op       = op;
    b.slot     = slot;
    b.word     = word;
    b.px       = $urandom;
    b.py       = $urandom;
    b.pz       = $urandom;
    b.nan      = 1'($urandom);
    b.strength = 8'($urandom);
    b.stamp    = {$urandom, $urandom};
    b.idx      = 16'($urandom);
    pending_beats = {pending_beats, b};
  endfunction

  // a full, sane pair of tables: vehicle near identity so the box gets hit
  function automatic void queue_coef_set();
    int s;
    for (s = 0; s < NUM_SLOTS; s++) begin
      if (s >= ROT_SLOTS)
        push_load(OP_LOAD_VEH, 4'(s), 48'(int'($urandom_range(262144)) - 131072));
      else if (s % 4 == 0)
        push_load(OP_LOAD_VEH, 4'(s), $urandom_range(1) ? 48'sd1073741824
                                                        : -48'sd1073741824);
      else
        push_load(OP_LOAD_VEH, 4'(s), 48'(int'($urandom_range(268435456)) - 134217728));
      push_load(OP_LOAD_WLD, 4'(s), (s >= ROT_SLOTS) ? rand_trans() : rand_rot());
    end
  endfunction

  // random traffic: points mostly, stray loads (some to dead slots), op three
  function automatic void queue_random(input int n);
    int   i, k;
    logic [SLOT_W-1:0] s;
    queue_coef_set();
    for (i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 80) begin
        push_point(rand_coord(), rand_coord(), rand_coord(), $urandom_range(9) == 0);
      end else if (k < 95) begin
        s = 4'($urandom_range(15));
        push_load($urandom_range(1) ? OP_LOAD_VEH : OP_LOAD_WLD, s,
                  (s < ROT_SLOTS) ? rand_rot() : rand_trans());
      end else begin
        push_load(OP_NONE, 4'($urandom), rand48());
      end
    end
  endfunction

  // wait for the pipe to empty; drops leave no output, hence the slack
  task automatic drain();
    @(posedge clk_i);
    while (pending_beats.size() != 0 || s_axis_tvalid || kept_q.size() != 0)
      @(posedge clk_i);
    repeat (PIPE_SLACK) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_e idx, input logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    case (idx)
      CFG_INV_EN:   inv_en = val[0];
      CFG_BOX_EN:   box_en = val[0];
      CFG_BOX_X_HI: box_xh = longint'($signed(val));
      CFG_BOX_X_LO: box_xl = longint'($signed(val));
      CFG_BOX_Y_HI: box_yh = longint'($signed(val));
      CFG_BOX_Y_LO: box_yl = longint'($signed(val));
      CFG_HT_EN:    ht_en  = val[0];
      default:      ht_lim = longint'($signed(val));
    endcase
  endtask

  // only called with the pipe empty
  task automatic apply_config(input bit inv, input bit box,
                              input logic [31:0] xh, input logic [31:0] xl,
                              input logic [31:0] yh, input logic [31:0] yl,
                              input bit ht, input logic [31:0] lim);
    write_reg(CFG_INV_EN,   {31'b0, inv});
    write_reg(CFG_BOX_EN,   {31'b0, box});
    write_reg(CFG_BOX_X_HI, xh);
    write_reg(CFG_BOX_X_LO, xl);
    write_reg(CFG_BOX_Y_HI, yh);
    write_reg(CFG_BOX_Y_LO, yl);
    write_reg(CFG_HT_EN,    {31'b0, ht});
    write_reg(CFG_HT_LIMIT, lim);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(input int n, input int sidle, input int rstall,
                           input bit long_hold);
    @(negedge clk_i);
    send_idle_pct  = sidle;
    recv_stall_pct = rstall;
    queue_random(n);
    if (long_hold) hold_req = ~hold_req;
    drain();
  endtask

  // ---- test sequence
  initial begin
    int i;
    // model state after reset
    inv_en = INV_EN_RST;
    box_en = BOX_EN_RST;
    box_xh = longint'(BOX_X_HI_RST);
    box_xl = longint'(BOX_X_LO_RST);
    box_yh = longint'(BOX_Y_HI_RST);
    box_yl = longint'(BOX_Y_LO_RST);
    ht_en  = HT_EN_RST;
    ht_lim = longint'(HT_LIMIT_RST);
    for (i = 0; i < NUM_SLOTS; i++) begin
      veh_tab[i] = 0;
      wld_tab[i] = 0;
    end

    wait (rst_ni);
    @(negedge clk_i);

    // directed, reset register values
    push_point(32'sd65536, 32'sd0, 32'sd0, 1'b0);       // zero tables: inside box
    push_load(OP_NONE, 4'd2, 48'sd12345);               // op three, no effect
    push_load(OP_LOAD_VEH, 4'd0, 48'sd1073741824);      // vehicle = identity
    push_load(OP_LOAD_VEH, 4'd4, 48'sd1073741824);
    push_load(OP_LOAD_VEH, 4'd8, 48'sd1073741824);
    push_load(OP_LOAD_VEH, 4'd13, 48'sd5);              // dead slot, ignored
    push_point(32'sd65536, 32'sd65536, 32'sd0, 1'b0);   // well inside box
    push_point(32'sd131072, 32'sd0, 32'sd0, 1'b0);      // on x bound: kept
    push_point(-32'sd131072, -32'sd327680, 32'sd0, 1'b0); // on lower corner: kept
    push_point(32'sd131071, 32'sd196607, 32'sd0, 1'b0); // one lsb inside: dropped
    push_point(32'sd655360, 32'sd0, 32'sd0, 1'b1);      // NaN, filter off: kept
    // world: clamped rotations, translations at both 48-bit ends
    push_load(OP_LOAD_WLD, 4'd0, 48'sh7FFF_FFFF_FFFF);
    push_load(OP_LOAD_WLD, 4'd4, 48'sh8000_0000_0000);
    push_load(OP_LOAD_WLD, 4'd8, 48'sd1073741824);
    push_load(OP_LOAD_WLD, 4'd9, 48'sh7FFF_FFFF_FFFF);
    push_load(OP_LOAD_WLD, 4'd10, 48'sh8000_0000_0000);
    push_load(OP_LOAD_WLD, 4'd11, 48'sd0);
    push_point(Q16_MAX, Q16_MAX, Q16_MAX, 1'b0);        // world clamps both ways
    push_point(Q16_MIN, Q16_MIN, Q16_MIN, 1'b0);
    push_point(32'sd65536001, 32'sd0, 32'sd0, 1'b0);    // past 1000 m, filter off
    drain();

    // directed, range and height filters on
    apply_config(1'b1, 1'b1, BOX_X_HI_RST, BOX_X_LO_RST, BOX_Y_HI_RST,
                 BOX_Y_LO_RST, 1'b1, HT_LIMIT_RST);
    @(negedge clk_i);
    push_point(32'sd655360, 32'sd0, 32'sd0, 1'b1);      // NaN: dropped
    push_point(32'sd65536000, 32'sd0, 32'sd0, 1'b0);    // exactly 1000 m: kept
    push_point(32'sd65536001, 32'sd0, 32'sd0, 1'b0);    // just past: dropped
    push_point(32'sd655360, -32'sd65536001, 32'sd0, 1'b0);
    push_point(32'sd655360, 32'sd0, 32'sd327680, 1'b0); // at height limit: kept
    push_point(32'sd655360, 32'sd0, 32'sd327681, 1'b0); // above it: dropped
    drain();

    // random phases, each from an idle pipe
    apply_config(1'b1, 1'b1, 32'(int'($urandom_range(262144)) + 65536),
                 32'(-int'($urandom_range(262144)) - 65536),
                 32'(int'($urandom_range(262144)) + 65536),
                 32'(-int'($urandom_range(262144)) - 65536),
                 1'b1, 32'(int'($urandom_range(655360)) - 131072));
    run_phase(120, 0, 0, 1'b0);

    // widest box, but box filter off; height limit at the top
    apply_config(1'b0, 1'b0, Q16_MAX, Q16_MIN, Q16_MAX, Q16_MIN, 1'b1, Q16_MAX);
    run_phase(120, 57, 0, 1'b0);

    // inverted extreme box: nothing can be inside
    apply_config(1'b1, 1'b1, Q16_MIN, Q16_MAX, Q16_MIN, Q16_MAX, 1'b0, Q16_MIN);
    run_phase(120, 0, 57, 1'b0);

    apply_config(1'b1, 1'b1, 32'sd262144, -32'sd131072, 32'sd131072,
                 -32'sd393216, 1'b1, 32'sd0);
    run_phase(120, 28, 28, 1'b0);

    // back-pressure: output held while the sender keeps offering
    apply_config(1'b0, 1'b0, BOX_X_HI_RST, BOX_X_LO_RST, BOX_Y_HI_RST,
                 BOX_Y_LO_RST, 1'b0, HT_LIMIT_RST);
    run_phase(100, 0, 0, 1'b1);

    // lowest height limit: only z at the minimum survives
    apply_config(1'b0, 1'b1, BOX_X_HI_RST, BOX_X_LO_RST, BOX_Y_HI_RST,
                 BOX_Y_LO_RST, 1'b1, Q16_MIN);
    run_phase(40, 28, 28, 1'b0);

    apply_config(1'b1, 1'b1, BOX_X_HI_RST, BOX_X_LO_RST, BOX_Y_HI_RST,
                 BOX_Y_LO_RST, 1'b0, HT_LIMIT_RST);
    run_phase(90, 57, 57, 1'b0);

    repeat (PIPE_SLACK) @(posedge clk_i);
    if (kept_q.size() != 0) begin
      n_errors += kept_q.size();
      $display("%0t: %0d kept points never came out", $time, kept_q.size());
    end

    $display("Run covered %0d points (%0d filtered, %0d emitted and checked), %0d loads,",
             n_points, n_dropped, n_checked, n_loads);
    $display("  %0d ignored beats, eight register settings, idle/stall mixes and a long hold",
             n_ignored);
    if (n_errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
